// ===== src/xor_frame_checker_core_assert.svh =====
// Assertion macros for the XOR frame checker.
// Each macro expects signals named clock and reset in the scope where it is used.
// No other dependencies.
`ifndef XOR_FRAME_CHECKER_CORE_ASSERT_SVH
`define XOR_FRAME_CHECKER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define XFC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xfc assertion failed");

// The consequent holds in the cycle after the antecedent.
`define XFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xfc assertion failed");

`endif

// ===== src/xfc_pkg.sv =====
// Shared constants and types for the XOR frame checker.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package xfc_pkg;

   localparam int POS_W = 9;

   typedef logic [7:0]       byte_type;
   typedef logic [POS_W-1:0] pos_type;

   // Frame markers.
   localparam byte_type HDR_MARK = 8'hE1;
   localparam byte_type TRL_MARK = 8'hEF;

   // Positions of the fixed header fields and the payload start.
   localparam pos_type POS_HEADER    = 9'd0;
   localparam pos_type POS_LENGTH    = 9'd1;
   localparam pos_type POS_TYPE      = 9'd2;
   localparam pos_type PAYLOAD_START = 9'd3;

   // Frame size limits.
   localparam pos_type MIN_FRAME = 9'd5;
   localparam pos_type POS_LIMIT = 9'd256;

endpackage

// ===== src/xfc_if.sv =====
// Valid/ready channel interfaces for the XOR frame checker.
// Depends on xfc_pkg for the payload types.
`timescale 1ns / 1ps

interface xfc_req_if
   import xfc_pkg::*;
   ;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     end_of_frame;

   modport source (output valid, output data_byte, output end_of_frame, input ready);
   modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface xfc_rsp_if
   import xfc_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     frame_ok;
   byte_type frame_type;
   pos_type  frame_length;

   modport source (output valid, output frame_ok, output frame_type, output frame_length,
                   input ready);
   modport sink   (input valid, input frame_ok, input frame_type, input frame_length,
                   output ready);
endinterface

// ===== src/xor_frame_checker_core.sv =====
// XOR frame checker: one byte item per cycle while the result register is free or is being
// emptied, a verdict item on each end-of-frame byte. The verdict enters the result register
// in the cycle after the last byte is accepted. The per-byte state update and the verdict
// are one combinational pass between the input handshake and the state and result registers.
// Reset: synchronous, active high; clears the frame state and the result valid flag.
`timescale 1ns / 1ps
`include "xor_frame_checker_core_assert.svh"

module xor_frame_checker_core
   import xfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   xfc_req_if.sink   req_chan,
   xfc_rsp_if.source rsp_chan
);

   // Frame state.
   pos_type  pos_ff, pos_in;
   logic     hdr_seen_ff, hdr_seen_in;
   byte_type decl_len_ff, decl_len_in;
   byte_type type_byte_ff, type_byte_in;
   byte_type pay_xor_ff, pay_xor_in;
   byte_type prev_byte_ff, prev_byte_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_ok_ff, rsp_ok_in;
   byte_type rsp_type_ff, rsp_type_in;
   pos_type  rsp_len_ff, rsp_len_in;

   logic     req_fire;
   logic     rsp_fire;
   logic     last;
   byte_type data;
   logic     hdr_now;
   byte_type len_now;
   byte_type type_now;
   pos_type  size;
   logic     ok;

   // The result register frees up in the same cycle its item is taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;
   assign last           = req_chan.end_of_frame;
   assign data           = req_chan.data_byte;

   // Header fields as seen including the current byte.
   assign hdr_now  = (pos_ff == POS_HEADER) ? (data == HDR_MARK) : hdr_seen_ff;
   assign len_now  = (pos_ff == POS_LENGTH) ? data : decl_len_ff;
   assign type_now = (pos_ff == POS_TYPE)   ? data : type_byte_ff;

   // Frame size, saturated at the position limit.
   assign size = (pos_ff == POS_LIMIT) ? POS_LIMIT : pos_ff + 9'd1;

   // Verdict for a frame ending on the current byte.
   assign ok = (size >= MIN_FRAME) && !size[POS_W-1] && hdr_now && (data == TRL_MARK) &&
               ({1'b0, len_now} == size) && (prev_byte_ff == pay_xor_ff);

   // Next frame state.
   always_comb begin
      pos_in       = pos_ff;
      hdr_seen_in  = hdr_seen_ff;
      decl_len_in  = decl_len_ff;
      type_byte_in = type_byte_ff;
      pay_xor_in   = pay_xor_ff;
      prev_byte_in = prev_byte_ff;
      if (req_fire) begin
         if (last) begin
            pos_in       = '0;
            hdr_seen_in  = 1'b0;
            decl_len_in  = '0;
            type_byte_in = '0;
            pay_xor_in   = '0;
            prev_byte_in = '0;
         end else begin
            hdr_seen_in  = hdr_now;
            decl_len_in  = len_now;
            type_byte_in = type_now;
            // The previous byte joins the payload once it lies at the payload start or later.
            if (pos_ff > PAYLOAD_START) begin
               pay_xor_in = pay_xor_ff ^ prev_byte_ff;
            end
            prev_byte_in = data;
            if (pos_ff != POS_LIMIT) begin
               pos_in = pos_ff + 9'd1;
            end
         end
      end
   end

   // Next result register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      rsp_ok_in    = rsp_ok_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_len_in   = rsp_len_ff;
      if (req_fire && last) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok;
         rsp_type_in  = (size >= PAYLOAD_START) ? type_now : '0;
         rsp_len_in   = size;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_seen_ff  <= 1'b0;
         decl_len_ff  <= '0;
         type_byte_ff <= '0;
         pay_xor_ff   <= '0;
         prev_byte_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hdr_seen_ff  <= hdr_seen_in;
         decl_len_ff  <= decl_len_in;
         type_byte_ff <= type_byte_in;
         pay_xor_ff   <= pay_xor_in;
         prev_byte_ff <= prev_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_type_ff <= rsp_type_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_ok     = rsp_ok_ff;
   assign rsp_chan.frame_type   = rsp_type_ff;
   assign rsp_chan.frame_length = rsp_len_ff;

   // The position never goes past the saturation limit.
   `XFC_ASSERT_SAME(a_pos_saturates, pos_ff[POS_W-1], pos_ff[POS_W-2:0] == '0)
   // An end-of-frame item always restarts the position count.
   `XFC_ASSERT_NEXT(a_eof_clears, req_fire && last, pos_ff == '0 && pay_xor_ff == '0)
   // A byte inside a frame advances the position unless it is saturated.
   `XFC_ASSERT_NEXT(a_pos_advances, req_fire && !last && !pos_ff[POS_W-1],
                    pos_ff == $past(pos_ff) + 9'd1)
   // A passing verdict always carries a length within the legal frame sizes.
   `XFC_ASSERT_SAME(a_ok_length, rsp_valid_ff && rsp_ok_ff,
                    rsp_len_ff >= MIN_FRAME && !rsp_len_ff[POS_W-1])
   // An empty result register never blocks the input.
   `XFC_ASSERT_SAME(a_ready_when_empty, !rsp_valid_ff, req_chan.ready)

endmodule

// ===== dv/xfc_verdict_checker.sv =====
// Scoreboard for the XOR frame checker: predicts one verdict per frame and compares it.
// Watches the byte and verdict channels passively; depends on xfc_pkg and xfc_if.
`timescale 1ns / 1ps

module xfc_verdict_checker
   import xfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   xfc_req_if          req_mon,
   xfc_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned verdicts_checked,
   output int unsigned verdicts_ok
);

   typedef struct packed {
      logic     ok;
      byte_type ftype;
      pos_type  flen;
   } verdict_type;

   // Verdicts predicted but not yet seen on the result channel, oldest first.
   verdict_type expected_verdicts[$];

   // Predicted frame state.
   pos_type  position;
   logic     header_ok;
   byte_type length_field;
   byte_type type_field;
   byte_type xor_sum;
   byte_type last_byte;

   task automatic clear_frame();
      position     = '0;
      header_ok    = 1'b0;
      length_field = '0;
      type_field   = '0;
      xor_sum      = '0;
      last_byte    = '0;
   endtask

   // Advance the frame state by one byte; the flagged last byte yields a verdict.
   task automatic advance_frame(input byte_type value, input logic last);
      pos_type     size;
      verdict_type v;
      if (position == POS_HEADER) header_ok = (value == HDR_MARK);
      if (position == POS_LENGTH) length_field = value;
      if (position == POS_TYPE) type_field = value;
      if (last) begin
         size    = (position == POS_LIMIT) ? POS_LIMIT : pos_type'(position + 1'b1);
         v.ok    = (size >= MIN_FRAME) && (size < POS_LIMIT) && header_ok &&
                   (value == TRL_MARK) && (pos_type'(length_field) == size) &&
                   (last_byte == xor_sum);
         v.ftype = (size > POS_TYPE) ? type_field : '0;
         v.flen  = size;
         expected_verdicts.push_back(v);
         clear_frame();
      end else begin
         // The byte before the current one belongs to the payload from position 3 on.
         if (position > PAYLOAD_START) xor_sum = xor_sum ^ last_byte;
         last_byte = value;
         if (position != POS_LIMIT) position = pos_type'(position + 1'b1);
      end
   endtask

   // Results are checked before the same edge's byte is predicted, since a verdict
   // can never leave in the cycle its last byte is accepted.
   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         clear_frame();
         expected_verdicts.delete();
         mismatches       = 0;
         verdicts_checked = 0;
         verdicts_ok      = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict item with no frame pending: frame_ok %0d frame_length %0d",
                      rsp_mon.frame_ok, rsp_mon.frame_length);
               mismatches++;
            end else begin
               exp_v = expected_verdicts.pop_front();
               verdicts_checked++;
               if (exp_v.ok) verdicts_ok++;
               if (rsp_mon.frame_ok !== exp_v.ok) begin
                  $error("frame_ok mismatch: expected %0d, actual %0d",
                         exp_v.ok, rsp_mon.frame_ok);
                  mismatches++;
               end
               if (rsp_mon.frame_type !== exp_v.ftype) begin
                  $error("frame_type mismatch: expected 0x%02h, actual 0x%02h",
                         exp_v.ftype, rsp_mon.frame_type);
                  mismatches++;
               end
               if (rsp_mon.frame_length !== exp_v.flen) begin
                  $error("frame_length mismatch: expected %0d, actual %0d",
                         exp_v.flen, rsp_mon.frame_length);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            advance_frame(req_mon.data_byte, req_mon.end_of_frame);
      end
      outstanding <= expected_verdicts.size();
   end

endmodule

// ===== dv/tb.sv =====
// Top of the XOR frame checker testbench: clock, reset, frame stimulus and verdict.
// Depends on xfc_pkg, xfc_if, xor_frame_checker_core and xfc_verdict_checker.
`timescale 1ns / 1ps

module tb;
   import xfc_pkg::*;

   typedef enum {FRAME_GOOD, FRAME_CORRUPT, FRAME_NOISE} frame_kind_type;

   localparam int unsigned BYTE_TARGET  = 1000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned DIRECTED_CNT = 26;

   // Directed frames: a lone byte, short frames of two to four bytes, valid frames of five
   // and six bytes, and a five-byte frame with a bad checksum.
   localparam int unsigned DIRECTED_SIZES [7] = '{1, 2, 3, 4, 5, 6, 5};
   localparam byte_type DIRECTED_BYTES [DIRECTED_CNT] = '{
      8'hFF,
      8'hE1, 8'hEF,
      8'hE1, 8'h03, 8'hEF,
      8'hE1, 8'h04, 8'h5A, 8'hEF,
      8'hE1, 8'h05, 8'hFF, 8'h00, 8'hEF,
      8'hE1, 8'h06, 8'h00, 8'hFF, 8'hFF, 8'hEF,
      8'hE1, 8'h05, 8'h42, 8'h01, 8'hEF
   };

   logic clock = 1'b0;
   logic reset;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned verdicts_checked;
   int unsigned verdicts_ok;

   int unsigned bytes_sent  = 0;
   int unsigned frames_sent = 0;
   int unsigned hold_asked  = 0;
   int unsigned hold_given  = 0;
   int unsigned quiet_count = 0;
   logic        no_idle     = 1'b0;

   xfc_req_if req_chan ();
   xfc_rsp_if rsp_chan ();

   xor_frame_checker_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   xfc_verdict_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .verdicts_checked (verdicts_checked),
      .verdicts_ok      (verdicts_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one byte item, wait for its acceptance, then idle for a random while.
   task automatic send_byte(input byte_type value, input logic last);
      int unsigned gap;
      req_chan.valid        <= 1'b1;
      req_chan.data_byte    <= value;
      req_chan.end_of_frame <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Build a frame of the given size with random content and send it.
   task automatic send_frame(input int unsigned size, input frame_kind_type kind);
      byte_type    bytes [];
      byte_type    sum;
      int unsigned k;
      bytes = new[size];
      for (k = 0; k < size; k++) bytes[k] = byte_type'($urandom_range(0, 255));
      if (kind != FRAME_NOISE) begin
         bytes[0] = HDR_MARK;
         if (size > 1) bytes[1] = byte_type'(size);
         sum = '0;
         for (k = 3; k + 2 < size; k++) sum = sum ^ bytes[k];
         if (size > 1) bytes[size-2] = sum;
         bytes[size-1] = TRL_MARK;
         if (kind == FRAME_CORRUPT)
            bytes[$urandom_range(0, size - 1)] ^= byte_type'($urandom_range(1, 255));
      end
      for (k = 0; k < size; k++) send_byte(bytes[k], k == size - 1);
      frames_sent++;
   endtask

   // Result side: random ready with long holds on request, always ready when asked.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asked != hold_given) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_given++;
         end else if (no_idle) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
      begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      int unsigned idx;
      int unsigned f;
      int unsigned n;
      int unsigned r;
      frame_kind_type kind;

      req_chan.valid        <= 1'b0;
      req_chan.data_byte    <= '0;
      req_chan.end_of_frame <= 1'b0;
      reset                 <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      idx = 0;
      for (f = 0; f < 7; f++) begin
         for (n = 0; n < DIRECTED_SIZES[f]; n++) begin
            send_byte(DIRECTED_BYTES[idx], n == DIRECTED_SIZES[f] - 1);
            idx++;
         end
         frames_sent++;
      end

      // Let every verdict drain before going on; the wait starts only once the count
      // includes the last accepted byte.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);

      // Back-to-back short frames against a long receiver hold, then a stretch
      // with no idling on either side.
      no_idle = 1'b1;
      hold_asked++;
      for (f = 0; f < 30; f++)
         send_frame($urandom_range(5, 8), ($urandom_range(0, 3) == 0) ? FRAME_CORRUPT
                                                                        : FRAME_GOOD);
      no_idle = 1'b0;

      // The largest valid frame and a frame that runs past the length saturation.
      send_frame(255, FRAME_GOOD);
      send_frame(258, FRAME_GOOD);

      // Random frames: mostly well formed, some corrupted, some noise.
      while (bytes_sent < BYTE_TARGET) begin
         r    = $urandom_range(0, 99);
         kind = (r < 70) ? FRAME_GOOD : (r < 90) ? FRAME_CORRUPT : FRAME_NOISE;
         r    = $urandom_range(0, 99);
         if (r < 8)
            send_frame($urandom_range(1, 4), kind);
         else if (r < 9)
            send_frame($urandom_range(250, 300), kind);
         else
            send_frame($urandom_range(5, 16), kind);
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      wait (outstanding == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d frames: short, long, corrupted and noise frames.",
               bytes_sent, frames_sent);
      $display("Compared %0d verdicts, %0d of them valid frames; %0d mismatches.",
               verdicts_checked, verdicts_ok, mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== xor_frame_checker_core.f =====
+incdir+src
src/xfc_pkg.sv
src/xfc_if.sv
src/xor_frame_checker_core.sv
dv/xfc_verdict_checker.sv
dv/tb.sv
